FILE: design/lir_pkg.sv
// Shared constants for the linear interpolation resampler.
// No dependencies; used by lir_div and linear_interp_resampler.
package lir_pkg;

  localparam int RATE_W    = 18;          // rate register width
  localparam int DEN_W     = RATE_W + 1;  // divisor width (covers 2 * target rate)
  localparam int IDX_W     = 32;          // position index / input counter width
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_RATE = 2'd1;

  localparam logic [RATE_W-1:0] SRC_RATE_RST = 18'd44100;
  localparam logic [RATE_W-1:0] DST_RATE_RST = 18'd48000;

endpackage

FILE: design/lir_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on lir_pkg (divisor width).
module lir_div #(
  parameter int NUM_W = 45
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start_i,
  input  logic [NUM_W-1:0]           num_i,
  input  logic [lir_pkg::DEN_W-1:0]  den_i,
  output logic                       busy_o,
  output logic [NUM_W-1:0]           quo_o,
  output logic [lir_pkg::DEN_W-1:0]  rmd_o
);

  localparam int DW    = lir_pkg::DEN_W;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q_r, q_nxt;
  logic [DW-1:0]    r_r, r_nxt;
  logic [DW-1:0]    den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [DW:0]      trial;
  logic [DW:0]      diff;
  logic             ge;

  assign trial = {r_r, q_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  always_comb begin
    q_nxt    = q_r;
    r_nxt    = r_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start_i) begin
      q_nxt    = num_i;
      r_nxt    = '0;
      den_nxt  = den_i;
      cnt_nxt  = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      r_nxt   = ge ? diff[DW-1:0] : trial[DW-1:0];
      q_nxt   = {q_r[NUM_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    r_r   <= r_nxt;
    den_r <= den_nxt;
  end

  assign busy_o = busy_r;
  assign quo_o  = q_r;
  assign rmd_o  = r_r;

endmodule

FILE: design/lir_mul.sv
// Registered signed-by-unsigned multiplier shared by interpolation and position jump.
// No package dependencies.
module lir_mul #(
  parameter int A_W = 25,
  parameter int B_W = 18
) (
  input  logic                     clk,
  input  logic                     en_i,
  input  logic signed [A_W-1:0]    a_i,
  input  logic [B_W-1:0]           b_i,
  output logic signed [A_W+B_W:0]  p_o
);

  logic signed [A_W+B_W:0] p_r;

  always_ff @(posedge clk) begin
    if (en_i) begin
      p_r <= a_i * $signed({1'b0, b_i});
    end
  end

  assign p_o = p_r;

endmodule

FILE: design/linear_interp_resampler.sv
// Linear interpolation sample rate converter; top level, sequencer and stream state.
// Uses lir_pkg, lir_div (serial divider) and lir_mul (registered multiplier).
// Equal rates pass each item straight through. Otherwise each interpolated output takes a
// division (one-bit-per-cycle divider) and outputs on the last sample take none; the ratio
// division runs on the first item after reset or a rate write, and a capped interval takes
// two divisions. Sync active-low reset: 44100/48000, state cleared.
module linear_interp_resampler #(
  parameter int MAX_PER_INPUT = 32,
  parameter int SAMPLE_BITS   = 24
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // input stream
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]        in_tdata,   // [SB-1:0] in_sample
  input  logic                                    in_tlast,   // in_last
  // result stream
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]        out_tdata,  // [SB-1:0] out_sample
  output logic                                    out_tlast,  // run_end
  output logic                                    out_tuser,  // [0] buffer_end
  // register writes
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [lir_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [lir_pkg::RATE_W-1:0]              cfg_data
);

  localparam int SB     = SAMPLE_BITS;
  localparam int TD_W   = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int RW     = lir_pkg::RATE_W;
  localparam int DW     = lir_pkg::DEN_W;
  localparam int IW     = lir_pkg::IDX_W;
  localparam int MA_W   = (SAMPLE_BITS + 1 > RW + 1) ? SAMPLE_BITS + 1 : RW + 1;
  localparam int P_W    = MA_W + RW + 1;
  localparam int NS_W   = P_W + 2;
  localparam int NUM_W  = P_W + 1;
  localparam int CNT_W  = $clog2(MAX_PER_INPUT + 1);

  // sequencer states
  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_RATIO   = 4'd1;   // start src/dst division
  localparam logic [3:0] ST_RATIO_W = 4'd2;
  localparam logic [3:0] ST_L1      = 4'd3;   // outputs between previous and current sample
  localparam logic [3:0] ST_MUL     = 4'd4;
  localparam logic [3:0] ST_IDIV    = 4'd5;
  localparam logic [3:0] ST_IDIV_W  = 4'd6;
  localparam logic [3:0] ST_PUT     = 4'd7;   // move finished value into the hold slot
  localparam logic [3:0] ST_JK      = 4'd8;   // jump: step count
  localparam logic [3:0] ST_JK_W    = 4'd9;
  localparam logic [3:0] ST_JM      = 4'd10;
  localparam logic [3:0] ST_JD      = 4'd11;  // jump: new position
  localparam logic [3:0] ST_JD_W    = 4'd12;
  localparam logic [3:0] ST_L2      = 4'd13;  // outputs lying on the last sample
  localparam logic [3:0] ST_END     = 4'd14;
  localparam logic [3:0] ST_FLUSH   = 4'd15;

  localparam logic [1:0] PH_L1  = 2'd0;
  localparam logic [1:0] PH_L2  = 2'd1;
  localparam logic [1:0] PH_END = 2'd2;

  logic [3:0]       state_r, state_nxt;
  logic [RW-1:0]    src_cfg_r, src_cfg_nxt;
  logic [RW-1:0]    dst_cfg_r, dst_cfg_nxt;
  logic             ratio_ok_r, ratio_ok_nxt;
  logic [RW-1:0]    ratio_q_r, ratio_q_nxt;      // src / dst
  logic [RW-1:0]    ratio_rm_r, ratio_rm_nxt;    // src % dst
  logic [SB-1:0]    prev_r, prev_nxt;
  logic             have_r, have_nxt;
  logic [IW-1:0]    seen_r, seen_nxt;
  logic [IW-1:0]    idx_r, idx_nxt;              // integer output position
  logic [RW-1:0]    frac_r, frac_nxt;            // fractional position, times dst
  logic [SB-1:0]    s_r, s_nxt;
  logic [SB-1:0]    a_r, a_nxt;
  logic [SB-1:0]    val_r, val_nxt;
  logic             last_r, last_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SB-1:0]    pend_r, pend_nxt;            // held result, flags not yet known
  logic             pend_v_r, pend_v_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic             neg_r, neg_nxt;
  logic             out_v_r, out_v_nxt;
  logic [SB-1:0]    out_sample_r, out_sample_nxt;
  logic             out_run_r, out_run_nxt;
  logic             out_buf_r, out_buf_nxt;

  logic [RW-1:0]    src_e, dst_e;
  logic             idx_at_prev, idx_at_cur;
  logic [RW+1:0]    sum_rs;
  logic             win1, win2, cnt_room, c1, c2;
  logic [RW:0]      adv_sum, adv_diff;
  logic             adv_c;
  logic [RW-1:0]    adv_frac;
  logic [IW-1:0]    adv_idx;
  logic             out_free;
  logic             in_acc, cfg_acc;
  logic [SB-1:0]    in_sample;

  logic [SB:0]      d_diff;
  logic [MA_W-1:0]  mul_a;
  logic [RW-1:0]    mul_b;
  logic             mul_en;
  logic [P_W-1:0]   mul_p;
  logic [NS_W-1:0]  inum_s, inum_abs;
  logic             inum_neg;
  logic [RW+1:0]    jk_num;

  logic             div_start, div_busy;
  logic [NUM_W-1:0] div_num, div_quo;
  logic [DW-1:0]    div_den, div_rmd;
  logic [SB-1:0]    q_mag, q_f;

  // a rate of zero behaves as one
  assign src_e = (src_cfg_r == '0) ? RW'(1) : src_cfg_r;
  assign dst_e = (dst_cfg_r == '0) ? RW'(1) : dst_cfg_r;

  assign in_sample = in_tdata[SB-1:0];
  assign cfg_ready = (state_r == ST_IDLE);
  assign in_tready = (state_r == ST_IDLE) && !cfg_valid;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign out_free  = !out_v_r || out_tready;

  // loop conditions; position compared relative to inputs seen
  assign idx_at_prev = (idx_r == seen_r - IW'(1));
  assign idx_at_cur  = (idx_r == seen_r);
  assign sum_rs      = {2'b00, frac_r} + {2'b00, src_e};
  assign win1        = (seen_r != '0) && (sum_rs <= {1'b0, dst_e, 1'b0});
  assign win2        = sum_rs <= {2'b00, dst_e};
  assign cnt_room    = cnt_r < CNT_W'(MAX_PER_INPUT);
  assign c1          = idx_at_prev && cnt_room && !(last_r && !win1);
  assign c2          = idx_at_cur && cnt_room && win2;

  // one output step: position += src/dst
  assign adv_sum  = {1'b0, frac_r} + {1'b0, ratio_rm_r};
  assign adv_diff = adv_sum - {1'b0, dst_e};
  assign adv_c    = adv_sum >= {1'b0, dst_e};
  assign adv_frac = adv_c ? adv_diff[RW-1:0] : adv_sum[RW-1:0];
  assign adv_idx  = idx_r + IW'(ratio_q_r) + IW'(adv_c);

  // multiplier operands: (b - a) * frac, or jump steps * src
  assign d_diff = {s_r[SB-1], s_r} - {a_r[SB-1], a_r};
  assign mul_a  = (state_r == ST_JM) ? MA_W'(div_quo[RW-1:0]) : MA_W'($signed(d_diff));
  assign mul_b  = (state_r == ST_JM) ? src_e : frac_r;
  assign mul_en = (state_r == ST_MUL) || (state_r == ST_JM);

  lir_mul #(
    .A_W (MA_W),
    .B_W (RW)
  ) u_mul (
    .clk  (clk),
    .en_i (mul_en),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .p_o  (mul_p)
  );

  // rounding numerator 2*(b-a)*frac + dst, split into sign and magnitude
  assign inum_s   = {mul_p[P_W-1], mul_p, 1'b0} + NS_W'(dst_e);
  assign inum_neg = inum_s[NS_W-1];
  assign inum_abs = inum_neg ? (~inum_s + NS_W'(1)) : inum_s;
  assign jk_num   = {2'b00, dst_e} - {2'b00, frac_r} + {2'b00, src_e} - (RW+2)'(1);

  assign div_start = (state_r == ST_RATIO) || (state_r == ST_JK) ||
                     (state_r == ST_JD) || (state_r == ST_IDIV);

  always_comb begin
    case (state_r)
      ST_RATIO: begin
        div_num = NUM_W'(src_e);
        div_den = {1'b0, dst_e};
      end
      ST_JK: begin
        div_num = NUM_W'(jk_num);
        div_den = {1'b0, src_e};
      end
      ST_JD: begin
        div_num = NUM_W'(mul_p) + NUM_W'(frac_r);
        div_den = {1'b0, dst_e};
      end
      default: begin
        div_num = inum_abs[NUM_W-1:0];
        div_den = {dst_e, 1'b0};
      end
    endcase
  end

  lir_div #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quo_o   (div_quo),
    .rmd_o   (div_rmd)
  );

  // floor division from truncated magnitude
  assign q_mag = div_quo[SB-1:0] + SB'(neg_r && (div_rmd != '0));
  assign q_f   = neg_r ? (~q_mag + SB'(1)) : q_mag;

  always_comb begin
    state_nxt      = state_r;
    src_cfg_nxt    = src_cfg_r;
    dst_cfg_nxt    = dst_cfg_r;
    ratio_ok_nxt   = ratio_ok_r;
    ratio_q_nxt    = ratio_q_r;
    ratio_rm_nxt   = ratio_rm_r;
    prev_nxt       = prev_r;
    have_nxt       = have_r;
    seen_nxt       = seen_r;
    idx_nxt        = idx_r;
    frac_nxt       = frac_r;
    s_nxt          = s_r;
    a_nxt          = a_r;
    val_nxt        = val_r;
    last_nxt       = last_r;
    cnt_nxt        = cnt_r;
    pend_nxt       = pend_r;
    pend_v_nxt     = pend_v_r;
    phase_nxt      = phase_r;
    neg_nxt        = neg_r;
    out_v_nxt      = out_v_r && !out_tready;
    out_sample_nxt = out_sample_r;
    out_run_nxt    = out_run_r;
    out_buf_nxt    = out_buf_r;

    case (state_r)
      ST_IDLE: begin
        if (cfg_acc) begin
          // a rate write restarts the stream
          if (cfg_index == lir_pkg::CFG_SRC_RATE || cfg_index == lir_pkg::CFG_DST_RATE) begin
            if (cfg_index == lir_pkg::CFG_SRC_RATE) begin
              src_cfg_nxt = cfg_data;
            end else begin
              dst_cfg_nxt = cfg_data;
            end
            ratio_ok_nxt = 1'b0;
            have_nxt     = 1'b0;
            seen_nxt     = '0;
            idx_nxt      = '0;
            frac_nxt     = '0;
          end
        end else if (in_acc) begin
          s_nxt    = in_sample;
          last_nxt = in_tlast;
          a_nxt    = have_r ? prev_r : in_sample;
          cnt_nxt  = '0;
          if (src_e == dst_e) begin
            // pass-through
            pend_nxt   = in_sample;
            pend_v_nxt = 1'b1;
            state_nxt  = ST_FLUSH;
          end else if (!ratio_ok_r) begin
            state_nxt = ST_RATIO;
          end else begin
            state_nxt = ST_L1;
          end
        end
      end
      ST_RATIO: begin
        state_nxt = ST_RATIO_W;
      end
      ST_RATIO_W: begin
        if (!div_busy) begin
          ratio_q_nxt  = div_quo[RW-1:0];
          ratio_rm_nxt = div_rmd[RW-1:0];
          ratio_ok_nxt = 1'b1;
          state_nxt    = ST_L1;
        end
      end
      ST_L1: begin
        if (have_r && c1) begin
          phase_nxt = PH_L1;
          state_nxt = ST_MUL;
        end else if (have_r && !last_r && idx_at_prev) begin
          state_nxt = ST_JK;   // output cap hit: skip rest of this interval
        end else if (last_r) begin
          state_nxt = ST_L2;
        end else begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_MUL: begin
        state_nxt = ST_IDIV;
      end
      ST_IDIV: begin
        neg_nxt   = inum_neg;
        state_nxt = ST_IDIV_W;
      end
      ST_IDIV_W: begin
        if (!div_busy) begin
          val_nxt   = a_r + q_f;
          state_nxt = ST_PUT;
        end
      end
      ST_PUT: begin
        if (!pend_v_r || out_free) begin
          if (pend_v_r) begin
            // another result follows, so the held one is not the last
            out_v_nxt      = 1'b1;
            out_sample_nxt = pend_r;
            out_run_nxt    = 1'b0;
            out_buf_nxt    = 1'b0;
          end
          pend_nxt   = val_r;
          pend_v_nxt = 1'b1;
          cnt_nxt    = cnt_r + CNT_W'(1);
          case (phase_r)
            PH_L1: begin
              idx_nxt   = adv_idx;
              frac_nxt  = adv_frac;
              state_nxt = ST_L1;
            end
            PH_L2: begin
              idx_nxt   = adv_idx;
              frac_nxt  = adv_frac;
              state_nxt = ST_L2;
            end
            default: begin
              state_nxt = ST_FLUSH;
            end
          endcase
        end
      end
      ST_JK: begin
        state_nxt = ST_JK_W;
      end
      ST_JK_W: begin
        if (!div_busy) begin
          state_nxt = ST_JM;
        end
      end
      ST_JM: begin
        state_nxt = ST_JD;
      end
      ST_JD: begin
        state_nxt = ST_JD_W;
      end
      ST_JD_W: begin
        if (!div_busy) begin
          idx_nxt   = idx_r + div_quo[IW-1:0];
          frac_nxt  = div_rmd[RW-1:0];
          state_nxt = ST_FLUSH;
        end
      end
      ST_L2: begin
        if (c2) begin
          val_nxt   = s_r;
          phase_nxt = PH_L2;
          state_nxt = ST_PUT;
        end else begin
          state_nxt = ST_END;
        end
      end
      ST_END: begin
        // buffer that produced nothing still gives one result
        if (idx_r == '0 && frac_r == '0 && cnt_r == '0) begin
          val_nxt   = a_r;
          phase_nxt = PH_END;
          state_nxt = ST_PUT;
        end else begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!pend_v_r || out_free) begin
          if (pend_v_r) begin
            out_v_nxt      = 1'b1;
            out_sample_nxt = pend_r;
            out_run_nxt    = 1'b1;
            out_buf_nxt    = last_r;
          end
          pend_v_nxt = 1'b0;
          if (last_r) begin
            have_nxt = 1'b0;
            seen_nxt = '0;
            idx_nxt  = '0;
            frac_nxt = '0;
          end else begin
            prev_nxt = s_r;
            have_nxt = 1'b1;
            seen_nxt = seen_r + IW'(1);
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      src_cfg_r  <= lir_pkg::SRC_RATE_RST;
      dst_cfg_r  <= lir_pkg::DST_RATE_RST;
      ratio_ok_r <= 1'b0;
      have_r     <= 1'b0;
      seen_r     <= '0;
      idx_r      <= '0;
      frac_r     <= '0;
      cnt_r      <= '0;
      pend_v_r   <= 1'b0;
      phase_r    <= PH_L1;
      out_v_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      src_cfg_r  <= src_cfg_nxt;
      dst_cfg_r  <= dst_cfg_nxt;
      ratio_ok_r <= ratio_ok_nxt;
      have_r     <= have_nxt;
      seen_r     <= seen_nxt;
      idx_r      <= idx_nxt;
      frac_r     <= frac_nxt;
      cnt_r      <= cnt_nxt;
      pend_v_r   <= pend_v_nxt;
      phase_r    <= phase_nxt;
      out_v_r    <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ratio_q_r    <= ratio_q_nxt;
    ratio_rm_r   <= ratio_rm_nxt;
    prev_r       <= prev_nxt;
    s_r          <= s_nxt;
    a_r          <= a_nxt;
    val_r        <= val_nxt;
    last_r       <= last_nxt;
    pend_r       <= pend_nxt;
    neg_r        <= neg_nxt;
    out_sample_r <= out_sample_nxt;
    out_run_r    <= out_run_nxt;
    out_buf_r    <= out_buf_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = TD_W'(out_sample_r);
  assign out_tlast  = out_run_r;
  assign out_tuser  = out_buf_r;

`ifndef SYNTHESIS
  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    frac_r < dst_e)
    else $error("fractional position not below target rate");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (!pend_v_r && !div_busy))
    else $error("input ready while item work is outstanding");

  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_PER_INPUT))
    else $error("output count exceeds per-input cap");
`endif

endmodule
